FILE: design/flsm_pkg.sv
package flsm_pkg;

    localparam int MAX_PATTERN_DEF   = 512;
    localparam int POSITION_BITS_DEF = 32;
    localparam int MATCH_START_W     = 32;

    typedef logic [1:0] action_t;
    typedef logic [1:0] status_t;

    localparam action_t ACT_CLEAR  = 2'd0;
    localparam action_t ACT_APPEND = 2'd1;
    localparam action_t ACT_TEXT   = 2'd2;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

endpackage

FILE: design/failure_link_stream_matcher_unit.sv
// Streaming Knuth-Morris-Pratt matcher. Each input item is a clear, a pattern
// append or a text byte (kind in s_tuser), and each one returns exactly one
// result item. Clear, error and unused-action items and the first append finish
// in the cycle they are accepted. Another append or a text byte goes through
// S_CMP, then S_FRD and S_CMP again for every failure link followed, then S_MFIN
// when a text byte completes a match; the failure walk runs on one compare
// unit reading the pattern and failure memories, one registered read each
// per cycle. A new item is accepted while a finished result waits on m_tready;
// s_tready is low while an item is worked on or a result waits in the pending slot.
module failure_link_stream_matcher_unit
    import flsm_pkg::*;
#(
    parameter int MAX_PATTERN   = MAX_PATTERN_DEF,
    parameter int POSITION_BITS = POSITION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_value
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [0] match_found, [32:1] match_start, [34:33] status
);

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CNT_W = $clog2(MAX_PATTERN + 1);
    localparam int POS_W = POSITION_BITS;
    localparam int SW    = (POS_W > CNT_W) ? POS_W : CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,
        S_FRD,
        S_MFIN,
        S_OUT
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   plb_reg, plb_next;
    logic [IDX_W-1:0]   matched_reg, matched_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [7:0]         char_reg, char_next;
    logic               is_text_reg, is_text_next;

    logic               m_tvalid_reg, m_tvalid_next;
    logic               m_found_reg, m_found_next;
    logic [MATCH_START_W-1:0] m_start_reg, m_start_next;
    status_t            m_status_reg, m_status_next;
    logic               pend_found_reg, pend_found_next;
    logic [MATCH_START_W-1:0] pend_start_reg, pend_start_next;
    status_t            pend_status_reg, pend_status_next;

    logic [7:0]         pmem [MAX_PATTERN];
    logic [IDX_W-1:0]   fmem [MAX_PATTERN];
    logic [7:0]         p_q_reg;
    logic [IDX_W-1:0]   f_q_reg;

    logic [IDX_W-1:0]   p_addr, f_addr, p_waddr, f_waddr, f_wdata;
    logic               p_we, f_we;

    logic               fin, fin_found;
    logic [MATCH_START_W-1:0] fin_start;
    status_t            fin_status;
    logic               out_free, char_match;
    logic [CNT_W-1:0]   jn;
    logic [IDX_W-1:0]   j0;
    logic [POS_W-1:0]   pos_inc;
    logic [SW-1:0]      back_w, pos_w, start_w;
    logic [SW+MATCH_START_W-1:0] start_wide;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, m_status_reg, m_start_reg, m_found_reg};

    assign out_free   = !m_tvalid_reg || m_tready;
    assign char_match = (p_q_reg == char_reg);
    assign jn         = CNT_W'(j_reg) + CNT_W'(char_match);
    assign j0         = (CNT_W'(matched_reg) >= count_reg) ? '0 : matched_reg;
    assign pos_inc    = (pos_reg == '1) ? pos_reg : pos_reg + POS_W'(1);
    assign back_w     = SW'(count_reg) - SW'(1);
    assign pos_w      = SW'(pos_reg);
    assign start_w    = (pos_w >= back_w) ? (pos_w - back_w) : '0;
    assign start_wide = {{MATCH_START_W{1'b0}}, start_w};

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        plb_next         = plb_reg;
        matched_next     = matched_reg;
        pos_next         = pos_reg;
        j_next           = j_reg;
        char_next        = char_reg;
        is_text_next     = is_text_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_found_next     = m_found_reg;
        m_start_next     = m_start_reg;
        m_status_next    = m_status_reg;
        pend_found_next  = pend_found_reg;
        pend_start_next  = pend_start_reg;
        pend_status_next = pend_status_reg;
        p_addr           = j_reg;
        f_addr           = j_reg - IDX_W'(1);
        p_we             = 1'b0;
        p_waddr          = count_reg[IDX_W-1:0];
        f_we             = 1'b0;
        f_waddr          = count_reg[IDX_W-1:0];
        f_wdata          = '0;
        fin              = 1'b0;
        fin_found        = 1'b0;
        fin_start        = '0;
        fin_status       = ST_OK;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    char_next = s_tdata;
                    case (s_tuser)
                        ACT_CLEAR: begin
                            count_next   = '0;
                            plb_next     = '0;
                            matched_next = '0;
                            pos_next     = '0;
                            fin          = 1'b1;
                        end
                        ACT_APPEND: begin
                            if (count_reg == CNT_W'(MAX_PATTERN)) begin
                                fin_status = ST_FULL;
                                fin        = 1'b1;
                            end else begin
                                p_we = 1'b1;
                                if (count_reg == '0) begin
                                    f_we       = 1'b1;
                                    plb_next   = '0;
                                    count_next = CNT_W'(1);
                                    fin        = 1'b1;
                                end else begin
                                    j_next       = plb_reg;
                                    p_addr       = plb_reg;
                                    is_text_next = 1'b0;
                                    state_next   = S_CMP;
                                end
                            end
                        end
                        ACT_TEXT: begin
                            if (count_reg == '0) begin
                                fin_status = ST_EMPTY;
                                pos_next   = pos_inc;
                                fin        = 1'b1;
                            end else begin
                                j_next       = j0;
                                p_addr       = j0;
                                is_text_next = 1'b1;
                                state_next   = S_CMP;
                            end
                        end
                        default: begin
                            fin = 1'b1;
                        end
                    endcase
                end
            end
            S_CMP: begin
                if (!char_match && j_reg != '0) begin
                    // follow the failure link
                    f_addr     = j_reg - IDX_W'(1);
                    state_next = S_FRD;
                end else if (!is_text_reg) begin
                    f_we       = 1'b1;
                    f_wdata    = jn[IDX_W-1:0];
                    plb_next   = jn[IDX_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                    fin        = 1'b1;
                end else if (jn == count_reg) begin
                    f_addr     = back_w[IDX_W-1:0];
                    state_next = S_MFIN;
                end else begin
                    matched_next = jn[IDX_W-1:0];
                    pos_next     = pos_inc;
                    fin          = 1'b1;
                end
            end
            S_FRD: begin
                j_next     = f_q_reg;
                p_addr     = f_q_reg;
                state_next = S_CMP;
            end
            S_MFIN: begin
                matched_next = f_q_reg;
                pos_next     = pos_inc;
                fin_found    = 1'b1;
                fin_start    = start_wide[MATCH_START_W-1:0];
                fin          = 1'b1;
            end
            S_OUT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_found_next  = pend_found_reg;
                    m_start_next  = pend_start_reg;
                    m_status_next = pend_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // deliver now if the output slot is free, else hold in the pending slot
        if (fin) begin
            if (out_free) begin
                m_tvalid_next = 1'b1;
                m_found_next  = fin_found;
                m_start_next  = fin_start;
                m_status_next = fin_status;
                state_next    = S_IDLE;
            end else begin
                pend_found_next  = fin_found;
                pend_start_next  = fin_start;
                pend_status_next = fin_status;
                state_next       = S_OUT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (p_we) begin
            pmem[p_waddr] <= char_next;
        end
        p_q_reg <= pmem[p_addr];
    end

    always_ff @(posedge aclk) begin
        if (f_we) begin
            fmem[f_waddr] <= f_wdata;
        end
        f_q_reg <= fmem[f_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            plb_reg      <= '0;
            matched_reg  <= '0;
            pos_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            plb_reg      <= plb_next;
            matched_reg  <= matched_next;
            pos_reg      <= pos_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        j_reg           <= j_next;
        char_reg        <= char_next;
        is_text_reg     <= is_text_next;
        m_found_reg     <= m_found_next;
        m_start_reg     <= m_start_next;
        m_status_reg    <= m_status_next;
        pend_found_reg  <= pend_found_next;
        pend_start_reg  <= pend_start_next;
        pend_status_reg <= pend_status_next;
    end

endmodule

FILE: bench/failure_link_stream_matcher_unit_test.sv
module failure_link_stream_matcher_unit_test;
    import flsm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam action_t     ACT_UNUSED   = 2'd3;
    localparam int          ITEM_TARGET  = 1900;
    localparam int          CYCLE_LIMIT  = 1_000_000;
    localparam int          HOLD_CYCLES  = 400;
    localparam int          DRAIN_CYCLES = 1100;
    localparam logic [63:0] POS_MAX      = (64'd1 << POSITION_BITS_DEF) - 64'd1;

    // status in the top bits, match_found in bit 0, same layout as m_tdata[34:0]
    typedef struct packed {
        status_t     status;
        logic [31:0] start;
        logic        found;
    } result_t;

    typedef struct {
        action_t     act;
        logic [7:0]  ch;
        bit          typed;
        result_t     exp;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] char_value
    logic [1:0]  s_tuser;   // [1:0] action
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [0] match_found, [32:1] match_start, [34:33] status

    failure_link_stream_matcher_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #1 aclk = ~aclk;

    // matcher state as predicted
    logic [7:0]  pattern_bytes [MAX_PATTERN_DEF];
    int unsigned link_table [MAX_PATTERN_DEF];
    int unsigned pattern_len;
    int unsigned link_build;
    int unsigned matched_len;
    logic [63:0] text_pos;

    result_t     pending_results [$];
    int          fail_count;
    int          items_sent;
    int          burst_left;
    bit          hold_request;
    longint      cycle_count;
    row_t        directed_rows [22];

    task automatic predict_match(input action_t act, input logic [7:0] ch,
                                 output result_t res);
        int unsigned j;
        int unsigned len;
        logic [63:0] origin;
        res = '0;
        case (act)
            ACT_CLEAR: begin
                pattern_len = 0;
                link_build  = 0;
                matched_len = 0;
                text_pos    = '0;
            end
            ACT_APPEND: begin
                if (pattern_len >= MAX_PATTERN_DEF) begin
                    res.status = ST_FULL;
                end else begin
                    pattern_bytes[pattern_len] = ch;
                    len = 0;
                    if (pattern_len != 0) begin
                        len = link_build;
                        while (len > 0 && pattern_bytes[len] != ch)
                            len = link_table[len - 1];
                        if (pattern_bytes[len] == ch)
                            len++;
                    end
                    link_table[pattern_len] = len;
                    link_build = len;
                    pattern_len++;
                end
            end
            ACT_TEXT: begin
                if (pattern_len == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    j = matched_len;
                    if (j >= pattern_len)
                        j = 0;
                    while (j > 0 && pattern_bytes[j] != ch)
                        j = link_table[j - 1];
                    if (pattern_bytes[j] == ch)
                        j++;
                    if (j == pattern_len) begin
                        origin = (text_pos >= 64'(pattern_len - 1))
                                 ? text_pos - 64'(pattern_len - 1) : 64'd0;
                        res.found = 1'b1;
                        res.start = origin[31:0];
                        j = link_table[j - 1];
                    end
                    matched_len = j;
                end
                if (text_pos < POS_MAX)
                    text_pos++;
            end
            default: ;
        endcase
    endtask

    // offer one item in the current burst and record what it must answer
    task automatic offer_item(input action_t act, input logic [7:0] ch,
                              input bit typed, input result_t typed_res);
        result_t res;
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                               : $urandom_range(0, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 20);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tuser  <= act;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        predict_match(act, ch, res);
        pending_results.push_back(typed ? typed_res : res);
        if (act != ACT_UNUSED)
            items_sent++;
    endtask

    // result checking
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        got = m_tdata[34:0];
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: status %0d start %0d found %0d",
                             got.status, got.start, got.found);
            end else begin
                want = pending_results.pop_front();
                if (got.found !== want.found || got.start !== want.start ||
                    got.status !== want.status) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: expected status %0d start %0d found %0d, %s%0d %s%0d %s%0d",
                                 want.status, want.start, want.found,
                                 "got status ", got.status, "start ", got.start,
                                 "found ", got.found);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: stall pattern changes phase by phase, one long hold on request
    initial begin
        int ready_mode;
        int phase_left;
        logic [7:0] rot;
        ready_mode = 0;
        phase_left = 0;
        rot = 8'b1011_0010;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if (phase_left == 0) begin
                ready_mode = $urandom_range(0, 3);
                phase_left = $urandom_range(16, 128);
                rot = 8'($urandom_range(1, 255));
            end
            phase_left--;
            case (ready_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 1) == 1);
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: begin
                    rot = {rot[6:0], rot[7]};
                    m_tready <= rot[0];
                end
            endcase
        end
    end

    initial begin
        logic [7:0] motif [3];
        logic [7:0] alpha [3];
        int period;
        int nalpha;
        int plen;
        int tlen;
        int kind;
        int r;
        result_t blank;

        blank        = '0;
        fail_count   = 0;
        items_sent   = 0;
        burst_left   = 0;
        hold_request = 1'b0;
        cycle_count  = 0;
        pattern_len  = 0;
        link_build   = 0;
        matched_len  = 0;
        text_pos     = '0;

        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= ACT_CLEAR;

        directed_rows = '{
            '{ACT_TEXT,   8'h00, 1'b1, '{ST_EMPTY, 32'd0, 1'b0}},
            '{ACT_UNUSED, 8'hFF, 1'b1, '{ST_OK,    32'd0, 1'b0}},
            '{ACT_CLEAR,  8'hFF, 1'b1, '{ST_OK,    32'd0, 1'b0}},
            '{ACT_APPEND, 8'hFF, 1'b1, '{ST_OK,    32'd0, 1'b0}},
            '{ACT_APPEND, 8'h00, 1'b1, '{ST_OK,    32'd0, 1'b0}},
            '{ACT_APPEND, 8'hFF, 1'b1, '{ST_OK,    32'd0, 1'b0}},
            '{ACT_TEXT,   8'hFF, 1'b0, '{ST_OK,    32'd0, 1'b0}},
            '{ACT_TEXT,   8'h00, 1'b0, '{ST_OK,    32'd0, 1'b0}},
            '{ACT_TEXT,   8'hFF, 1'b0, '{ST_OK,    32'd0, 1'b0}},
            '{ACT_TEXT,   8'h00, 1'b0, '{ST_OK,    32'd0, 1'b0}},
            '{ACT_TEXT,   8'hFF, 1'b0, '{ST_OK,    32'd0, 1'b0}},
            '{ACT_APPEND, 8'h00, 1'b1, '{ST_OK,    32'd0, 1'b0}},
            '{ACT_TEXT,   8'h00, 1'b0, '{ST_OK,    32'd0, 1'b0}},
            '{ACT_TEXT,   8'hFF, 1'b0, '{ST_OK,    32'd0, 1'b0}},
            '{ACT_TEXT,   8'h00, 1'b0, '{ST_OK,    32'd0, 1'b0}},
            '{ACT_CLEAR,  8'h00, 1'b1, '{ST_OK,    32'd0, 1'b0}},
            '{ACT_TEXT,   8'h55, 1'b1, '{ST_EMPTY, 32'd0, 1'b0}},
            '{ACT_APPEND, 8'hAA, 1'b1, '{ST_OK,    32'd0, 1'b0}},
            '{ACT_TEXT,   8'hAA, 1'b0, '{ST_OK,    32'd0, 1'b0}},
            '{ACT_TEXT,   8'h55, 1'b0, '{ST_OK,    32'd0, 1'b0}},
            '{ACT_TEXT,   8'hAA, 1'b0, '{ST_OK,    32'd0, 1'b0}},
            '{ACT_UNUSED, 8'h00, 1'b1, '{ST_OK,    32'd0, 1'b0}}
        };

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            offer_item(directed_rows[i].act, directed_rows[i].ch,
                       directed_rows[i].typed, directed_rows[i].exp);

        // the long hold lands on the full-store run, so the block backs up
        hold_request = 1'b1;

        // fill the pattern store with a periodic pattern, overflow it once,
        // then stream matching text long enough to complete occurrences
        period = $urandom_range(1, 3);
        foreach (motif[i])
            motif[i] = 8'($urandom_range(0, 255));
        offer_item(ACT_CLEAR, 8'($urandom_range(0, 255)), 1'b0, blank);
        for (int i = 0; i <= MAX_PATTERN_DEF; i++)
            offer_item(ACT_APPEND, motif[i % period], 1'b0, blank);
        for (int i = 0; i < 600; i++) begin
            if ($urandom_range(0, 49) == 0)
                offer_item(ACT_TEXT, 8'($urandom_range(0, 255)), 1'b0, blank);
            else
                offer_item(ACT_TEXT, motif[i % period], 1'b0, blank);
        end

        while (items_sent < ITEM_TARGET) begin
            kind = $urandom_range(0, 99);
            if (kind < 90)
                offer_item(ACT_CLEAR, 8'($urandom_range(0, 255)), 1'b0, blank);
            if (kind < 6) begin
                // text against an empty pattern
                repeat ($urandom_range(1, 4))
                    offer_item(ACT_TEXT, 8'($urandom_range(0, 255)), 1'b0, blank);
            end
            nalpha = $urandom_range(1, 3);
            foreach (alpha[i])
                alpha[i] = 8'($urandom_range(0, 255));
            plen = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                : $urandom_range(1, 6);
            repeat (plen)
                offer_item(ACT_APPEND, alpha[$urandom_range(0, nalpha - 1)],
                           1'b0, blank);
            tlen = $urandom_range(10, 50);
            repeat (tlen) begin
                r = $urandom_range(0, 99);
                if (r < 2)
                    offer_item(ACT_UNUSED, 8'($urandom_range(0, 255)), 1'b0, blank);
                else if (r < 5)
                    offer_item(ACT_APPEND, alpha[$urandom_range(0, nalpha - 1)],
                               1'b0, blank);
                else if (r < 12)
                    offer_item(ACT_TEXT, 8'($urandom_range(0, 255)), 1'b0, blank);
                else
                    offer_item(ACT_TEXT, alpha[$urandom_range(0, nalpha - 1)],
                               1'b0, blank);
            end
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/flsm_pkg.sv
design/failure_link_stream_matcher_unit.sv
bench/failure_link_stream_matcher_unit_test.sv
